>>> design/gfau_pkg.sv
package gfau_pkg;

  localparam int ElemW = 8;
  localparam logic [ElemW:0] GfPoly = 9'h11b;
  localparam int InvSteps = 6;

  typedef logic [ElemW-1:0] elem_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t   op;
    elem_t a;
    elem_t b;
    elem_t acc;
  } stage_t;

  function automatic elem_t gf_mul(input elem_t x, input elem_t y);
    logic [2*ElemW-2:0] prod;
    prod = '0;
    for (int i = 0; i < ElemW; i++) begin
      if (y[i]) begin
        prod = prod ^ ({{(ElemW-1){1'b0}}, x} << i);
      end
    end
    for (int i = 2*ElemW-2; i >= ElemW; i--) begin
      if (prod[i]) begin
        prod = prod ^ ({{(ElemW-2){1'b0}}, GfPoly} << (i - ElemW));
      end
    end
    return prod[ElemW-1:0];
  endfunction

  function automatic elem_t gf_sq(input elem_t x);
    return gf_mul(x, x);
  endfunction

endpackage

>>> design/gfau_inv_step.sv
module gfau_inv_step (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  gfau_pkg::stage_t in_stg,
  output logic            out_vld,
  output gfau_pkg::stage_t out_stg
);
  import gfau_pkg::*;

  logic   vld_r;
  stage_t stg_r;
  stage_t stg_nxt;

  always_comb begin
    stg_nxt     = in_stg;
    stg_nxt.acc = gf_mul(gf_sq(in_stg.acc), in_stg.b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_stg = stg_r;

endmodule

>>> design/gf256_arithmetic_unit.sv
// channel | ports                                         | direction
// request | in_valid in_ready in_req_type in_operand_a/b | in
// result  | out_valid out_ready out_result out_div_by_zero| out
// One item enters per cycle when not stalled; six square-multiply steps
// build b^127, then a square, the final field multiply and the result
// select. Throughput is set by that single pipeline advancing.
// Synchronous active-low reset clears the valid bits only.
// A stalled output freezes every stage; bubbles travel as cleared valids.
module gf256_arithmetic_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_operand_a,
  input  logic [7:0] in_operand_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_result,
  output logic       out_div_by_zero
);
  import gfau_pkg::*;

  logic   en;
  logic   vld   [InvSteps+1];
  stage_t stg   [InvSteps+1];
  logic   out_valid_r;
  elem_t  result_r, result_nxt;
  logic   dbz_r, dbz_nxt;
  elem_t  inv;
  elem_t  mul_b;
  elem_t  prod;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign vld[0]     = in_valid;
  assign stg[0].op  = op_t'(in_req_type);
  assign stg[0].a   = in_operand_a;
  assign stg[0].b   = in_operand_b;
  assign stg[0].acc = in_operand_b;

  for (genvar k = 0; k < InvSteps; k++) begin : g_inv
    gfau_inv_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (vld[k]),
      .in_stg  (stg[k]),
      .out_vld (vld[k+1]),
      .out_stg (stg[k+1])
    );
  end

  always_comb begin
    inv        = gf_sq(stg[InvSteps].acc);
    mul_b      = (stg[InvSteps].op == OP_MUL) ? stg[InvSteps].b : inv;
    prod       = gf_mul(stg[InvSteps].a, mul_b);
    result_nxt = '0;
    dbz_nxt    = 1'b0;
    unique case (stg[InvSteps].op)
      OP_ADD, OP_SUB: result_nxt = stg[InvSteps].a ^ stg[InvSteps].b;
      OP_MUL:         result_nxt = prod;
      OP_DIV: begin
        result_nxt = prod;
        dbz_nxt    = (stg[InvSteps].b == '0);
      end
      default:        result_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[InvSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_r <= result_nxt;
      dbz_r    <= dbz_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result      = result_r;
  assign out_div_by_zero = dbz_r;

`ifndef SYNTHESIS
  a_dbz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_result == '0)
    else $error("divide by zero with nonzero result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without a stalled result");

  a_bubble_travels: assert property (@(posedge clk) disable iff (!rst_n)
    en && !vld[0] |=> !vld[1])
    else $error("first stage became valid without a transfer");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld[InvSteps]) && $stable(stg[InvSteps]))
    else $error("last stage moved during a stall");
`endif

endmodule

>>> dv/gf256_result_checker.sv
module gf256_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_operand_a,
  input  logic [7:0]  in_operand_b,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_result,
  input  logic        out_div_by_zero,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfau_pkg::*;

  typedef struct {
    op_t   op;
    elem_t a;
    elem_t b;
    elem_t value;
    logic  zero_div;
  } gf_answer_t;

  gf_answer_t answers_q[$];

  function automatic elem_t gf_product(input elem_t x, input elem_t y);
    elem_t p;
    elem_t m;
    logic  carry;
    p = '0;
    m = x;
    for (int i = 0; i < ElemW; i++) begin
      if (y[i]) begin
        p = p ^ m;
      end
      carry = m[ElemW-1];
      m = m << 1;
      if (carry) begin
        m = m ^ GfPoly[ElemW-1:0];
      end
    end
    return p;
  endfunction

  function automatic elem_t gf_reciprocal(input elem_t y);
    elem_t r;
    r = '0;
    for (int k = 1; k < 256; k++) begin
      if (gf_product(y, elem_t'(k)) == elem_t'(1)) begin
        r = elem_t'(k);
      end
    end
    return r;
  endfunction

  function automatic gf_answer_t gf_compute(input op_t op, input elem_t a, input elem_t b);
    gf_answer_t ans;
    ans.op       = op;
    ans.a        = a;
    ans.b        = b;
    ans.value    = '0;
    ans.zero_div = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        ans.value = a ^ b;
      end
      OP_MUL: begin
        ans.value = gf_product(a, b);
      end
      OP_DIV: begin
        if (b == '0) begin
          ans.zero_div = 1'b1;
        end else begin
          ans.value = gf_product(a, gf_reciprocal(b));
        end
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t gf256 checker: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin
    gf_answer_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answers_q.size() == 0) begin
          report_mismatch($sformatf("result %02h flag %0b with no request outstanding",
                                    out_result, out_div_by_zero));
        end else begin
          want = answers_q.pop_front();
          if (out_result !== want.value) begin
            report_mismatch($sformatf("%s a=%02h b=%02h: result %02h, want %02h",
                                      want.op.name(), want.a, want.b, out_result, want.value));
          end
          if (out_div_by_zero !== want.zero_div) begin
            report_mismatch($sformatf("%s a=%02h b=%02h: div_by_zero %0b, want %0b",
                                      want.op.name(), want.a, want.b, out_div_by_zero,
                                      want.zero_div));
          end
        end
      end
      if (in_valid && in_ready) begin
        answers_q.push_back(gf_compute(op_t'(in_req_type), in_operand_a, in_operand_b));
      end
      pending <= answers_q.size();
    end
  end

endmodule

>>> dv/tb_gf256_arithmetic_unit.sv
module tb_gf256_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gfau_pkg::*;

  localparam int unsigned RandomRequests = 1600;
  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned TailCycles     = 20;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_req_type;
  logic [7:0] in_operand_a;
  logic [7:0] in_operand_b;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_result;
  logic       out_div_by_zero;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned req_stretch;
  bit          req_quiet;

  gf256_arithmetic_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_div_by_zero(out_div_by_zero)
  );

  gf256_result_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result     (out_result),
    .out_div_by_zero(out_div_by_zero),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_gf256_arithmetic_unit: FAIL");
      $finish;
    end
  end

  function automatic elem_t pick_elem();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'hff;
      3: return elem_t'(1 << $urandom_range(0, 7));
      default: return elem_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_request(input op_t op, input elem_t a, input elem_t b);
    int unsigned gap;
    if (req_stretch == 0) begin
      req_stretch = $urandom_range(16, 96);
      req_quiet   = ($urandom_range(0, 3) == 0);
    end
    req_stretch--;
    gap = req_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned stretch;
    bit          quiet;
    out_ready = 1'b0;
    stretch   = 0;
    quiet     = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(16, 96);
        quiet   = ($urandom_range(0, 3) == 0);
      end
      stretch--;
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = OP_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    req_stretch  = 0;
    req_quiet    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_request(OP_ADD, 8'h00, 8'h00);
    send_request(OP_ADD, 8'hff, 8'hff);
    send_request(OP_ADD, 8'ha5, 8'h5a);
    send_request(OP_SUB, 8'hff, 8'h00);
    send_request(OP_SUB, 8'h3c, 8'hc3);
    send_request(OP_MUL, 8'h00, 8'hff);
    send_request(OP_MUL, 8'hff, 8'h00);
    send_request(OP_MUL, 8'h00, 8'h00);
    send_request(OP_MUL, 8'hff, 8'hff);
    send_request(OP_MUL, 8'h80, 8'h02);
    send_request(OP_MUL, 8'h57, 8'h83);
    send_request(OP_MUL, 8'h01, 8'hb7);
    send_request(OP_DIV, 8'hff, 8'h00);
    send_request(OP_DIV, 8'h00, 8'h00);
    send_request(OP_DIV, 8'h5a, 8'h01);
    send_request(OP_DIV, 8'h01, 8'h01);
    send_request(OP_DIV, 8'h00, 8'hff);
    send_request(OP_DIV, 8'hff, 8'hff);
    send_request(OP_DIV, 8'h01, 8'h53);
    send_request(OP_DIV, 8'h80, 8'h80);
    send_request(OP_DIV, 8'hff, 8'h02);

    for (int n = 0; n < RandomRequests; n++) begin
      send_request(op_t'($urandom_range(0, 3)), pick_elem(), pick_elem());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_gf256_arithmetic_unit: PASS");
    end else begin
      $display("tb_gf256_arithmetic_unit: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/gfau_pkg.sv
design/gfau_inv_step.sv
design/gf256_arithmetic_unit.sv
dv/gf256_result_checker.sv
dv/tb_gf256_arithmetic_unit.sv
